/* rtl/dtimer_pkg.sv */
package dtimer_pkg;

   localparam int CounterBits = 14;
   localparam int DivLsb = 6;
   localparam logic [2:0] ReloadDelay = 3'd4;

   localparam logic [2:0] CmdTick = 3'd0;
   localparam logic [2:0] CmdWriteDiv = 3'd1;
   localparam logic [2:0] CmdWriteTima = 3'd2;
   localparam logic [2:0] CmdWriteTac = 3'd3;
   localparam logic [2:0] CmdWriteTma = 3'd4;

   localparam logic [1:0] RateBit9 = 2'd0;
   localparam logic [1:0] RateBit3 = 2'd1;
   localparam logic [1:0] RateBit5 = 2'd2;
   localparam logic [1:0] RateBit7 = 2'd3;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] div_value;
      logic [7:0] tima_value;
      logic [7:0] tma_value;
      logic [2:0] tac_value;
      logic       timer_irq;
   } rsp_type;

   // counter bit watched for the given rate select
   function automatic logic sel_bit(input logic [CounterBits-1:0] cnt,
                                    input logic [1:0] rate);
      logic b;
      case (rate)
         RateBit9: b = cnt[9];
         RateBit3: b = cnt[3];
         RateBit5: b = cnt[5];
         RateBit7: b = cnt[7];
         default:  b = 1'b0;
      endcase
      return b;
   endfunction

endpackage

/* rtl/divider_timer_with_delayed_reload.sv */
// Channel  | Signals                                                        | Moves
// ---------+----------------------------------------------------------------+---------------------
// request  | req_valid req_ready req_cmd req_write_data                     | tick or reg write
// response | rsp_valid rsp_ready rsp_{div,tima,tma,tac}_value rsp_timer_irq | DIV/TIMA/TMA/TAC, irq
//
// One request per cycle sustained while rsp_ready holds; a response passes through the request
// register, then the timer update into the response register, before it is valid.
// Synchronous reset clears counter, TIMA, TMA, TAC and the pending reload.
// A stalled response holds the pipeline; the request register still drains into an
// empty response slot, so back-pressure reaches req_ready only when both are full.
module divider_timer_with_delayed_reload
   import dtimer_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_div_value,
   output logic [7:0] rsp_tima_value,
   output logic [7:0] rsp_tma_value,
   output logic [2:0] rsp_tac_value,
   output logic       rsp_timer_irq
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff, out_rsp_in;
   logic    advance;
   rsp_type core_rsp;

   // move the held request into the response slot when that slot frees up
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in     = 1'b1;
         in_item_in.cmd  = req_cmd;
         in_item_in.write_data = req_write_data;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_rsp_in   = core_rsp;
      end
   end

   // timer state advances exactly once per request, as it enters the response slot
   dtimer_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_div_value  = out_rsp_ff.div_value;
   assign rsp_tima_value = out_rsp_ff.tima_value;
   assign rsp_tma_value  = out_rsp_ff.tma_value;
   assign rsp_tac_value  = out_rsp_ff.tac_value;
   assign rsp_timer_irq  = out_rsp_ff.timer_irq;

endmodule

/* rtl/dtimer_core.sv */
module dtimer_core
   import dtimer_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   output rsp_type result
);

   logic [CounterBits-1:0] cnt_ff, cnt_in;
   logic                   prev_ff, prev_in;
   logic [7:0]             tima_ff, tima_in;
   logic [7:0]             tma_ff, tma_in;
   logic [2:0]             tac_ff, tac_in;
   logic                   pending_ff, pending_in;
   logic [2:0]             countdown_ff, countdown_in;
   logic                   irq;
   logic                   do_edge;
   logic                   from_tick;
   logic                   cur_bit;
   logic                   incr;

   always_comb begin
      cnt_in       = cnt_ff;
      prev_in      = prev_ff;
      tima_in      = tima_ff;
      tma_in       = tma_ff;
      tac_in       = tac_ff;
      pending_in   = pending_ff;
      countdown_in = countdown_ff;
      irq          = 1'b0;
      do_edge      = 1'b0;
      from_tick    = 1'b0;
      cur_bit      = 1'b0;
      incr         = 1'b0;

      case (item.cmd)
         CmdTick: begin
            // pending reload counts down before the counter moves
            if (pending_ff) begin
               if (countdown_ff <= 3'd1) begin
                  countdown_in = 3'd0;
                  tima_in      = tma_ff;
                  pending_in   = 1'b0;
                  irq          = 1'b1;
               end else begin
                  countdown_in = countdown_ff - 3'd1;
               end
            end
            cnt_in    = cnt_ff + CounterBits'(1);
            do_edge   = 1'b1;
            from_tick = 1'b1;
         end
         CmdWriteDiv: begin
            cnt_in  = '0;
            do_edge = 1'b1;
         end
         CmdWriteTima: begin
            tima_in = item.write_data;
            prev_in = sel_bit(cnt_ff, tac_ff[1:0]);
         end
         CmdWriteTac: begin
            tac_in  = item.write_data[2:0];
            do_edge = 1'b1;
         end
         CmdWriteTma: begin
            tma_in = item.write_data;
         end
         default: begin
         end
      endcase

      if (do_edge) begin
         cur_bit = sel_bit(cnt_in, tac_in[1:0]);
         incr    = prev_ff & ~cur_bit & tac_in[2];
         if (incr) begin
            tima_in = tima_in + 8'd1;
            if (tima_in == 8'd0 && from_tick) begin
               pending_in   = 1'b1;
               countdown_in = ReloadDelay;
            end
         end
         prev_in = cur_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         prev_ff      <= 1'b0;
         tima_ff      <= '0;
         tma_ff       <= '0;
         tac_ff       <= '0;
         pending_ff   <= 1'b0;
         countdown_ff <= ReloadDelay;
      end else if (step_en) begin
         cnt_ff       <= cnt_in;
         prev_ff      <= prev_in;
         tima_ff      <= tima_in;
         tma_ff       <= tma_in;
         tac_ff       <= tac_in;
         pending_ff   <= pending_in;
         countdown_ff <= countdown_in;
      end
   end

   assign result.div_value  = cnt_in[DivLsb +: 8];
   assign result.tima_value = tima_in;
   assign result.tma_value  = tma_in;
   assign result.tac_value  = tac_in;
   assign result.timer_irq  = irq;

   a_irq_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      step_en && result.timer_irq |-> item.cmd == CmdTick && pending_ff)
      else $error("reload fired outside a pending tick");

   a_countdown_bound: assert property (@(posedge clock) disable iff (reset)
      countdown_ff <= ReloadDelay)
      else $error("reload countdown beyond its start value");

   a_write_keeps_pending: assert property (@(posedge clock) disable iff (reset)
      step_en && item.cmd != CmdTick |=> pending_ff == $past(pending_ff))
      else $error("register write changed the pending reload");

   a_fire_loads_tma: assert property (@(posedge clock) disable iff (reset)
      step_en && result.timer_irq && !incr |-> result.tima_value == tma_ff)
      else $error("reload did not load the modulo value");

endmodule

/* sim/tb_divider_timer_with_delayed_reload.sv */
module tb_divider_timer_with_delayed_reload;
   import dtimer_pkg::*;

   // Cycle budget: worst case is every request behind a full sender gap and a full
   // receiver stall, plus the drain pauses; take that several times over.
   localparam int CycleLimit = 400000;
   localparam int MaxIdle = 14;
   localparam int RequestTarget = 1750;
   localparam int HoldSpacing = 400;
   localparam int DrainCycles = 20;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data;
      logic       hold;   // wait for every response before sending this one
   } timer_request_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_cmd = CmdTick;
   logic [7:0] req_write_data = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_div_value;
   logic [7:0] rsp_tima_value;
   logic [7:0] rsp_tma_value;
   logic [2:0] rsp_tac_value;
   logic       rsp_timer_irq;

   timer_request_type pending_requests[$];
   rsp_type           expected_timer_state[$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                idle_left = 0;
   int                stall_left = 0;
   bit                sender_burst = 1'b0;
   bit                receiver_burst = 1'b0;

   // Predicted timer state
   logic [CounterBits-1:0] model_counter;
   logic                   model_prev_bit;
   logic [7:0]             model_tima;
   logic [7:0]             model_tma;
   logic [2:0]             model_tac;
   logic                   model_pending;
   logic [2:0]             model_countdown;

   divider_timer_with_delayed_reload dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_div_value  (rsp_div_value),
      .rsp_tima_value (rsp_tima_value),
      .rsp_tma_value  (rsp_tma_value),
      .rsp_tac_value  (rsp_tac_value),
      .rsp_timer_irq  (rsp_timer_irq)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Pick the counter bit that clocks TIMA for the given rate select.
   function automatic logic watched_bit(input logic [CounterBits-1:0] cnt,
                                        input logic [1:0] rate);
      logic b;
      case (rate)
         RateBit9: b = cnt[9];
         RateBit3: b = cnt[3];
         RateBit5: b = cnt[5];
         default:  b = cnt[7];
      endcase
      return b;
   endfunction

   task automatic clear_timer_model();
      model_counter = '0;
      model_prev_bit = 1'b0;
      model_tima = 8'd0;
      model_tma = 8'd0;
      model_tac = 3'd0;
      model_pending = 1'b0;
      model_countdown = ReloadDelay;
   endtask

   // Bump TIMA on a falling edge of the enabled, watched bit; only a tick arms a reload.
   task automatic run_edge_check(input bit from_tick);
      logic now_bit;
      now_bit = watched_bit(model_counter, model_tac[1:0]);
      if (model_prev_bit && !now_bit && model_tac[2]) begin
         model_tima = model_tima + 8'd1;
         if (model_tima == 8'd0 && from_tick) begin
            model_pending = 1'b1;
            model_countdown = ReloadDelay;
         end
      end
      model_prev_bit = now_bit;
   endtask

   // Apply one accepted request to the predicted state and queue the response it causes.
   task automatic predict_timer_response(input logic [2:0] cmd, input logic [7:0] data);
      rsp_type r;
      logic    irq;
      irq = 1'b0;
      case (cmd)
         CmdTick: begin
            // the pending reload counts down before the counter moves
            if (model_pending) begin
               if (model_countdown <= 3'd1) begin
                  model_countdown = 3'd0;
                  model_tima = model_tma;
                  model_pending = 1'b0;
                  irq = 1'b1;
               end else begin
                  model_countdown = model_countdown - 3'd1;
               end
            end
            model_counter = model_counter + CounterBits'(1);
            run_edge_check(1'b1);
         end
         CmdWriteDiv: begin
            model_counter = '0;
            run_edge_check(1'b0);
         end
         CmdWriteTima: begin
            model_tima = data;
            model_prev_bit = watched_bit(model_counter, model_tac[1:0]);
         end
         CmdWriteTac: begin
            model_tac = data[2:0];
            run_edge_check(1'b0);
         end
         CmdWriteTma: begin
            model_tma = data;
         end
         default: begin
            // unused codes leave the state alone
         end
      endcase
      r.div_value = model_counter[DivLsb +: 8];
      r.tima_value = model_tima;
      r.tma_value = model_tma;
      r.tac_value = model_tac;
      r.timer_irq = irq;
      expected_timer_state.push_back(r);
   endtask

   task automatic queue_request(input logic [2:0] cmd, input logic [7:0] data,
                                input logic hold);
      timer_request_type t;
      t.cmd = cmd;
      t.data = data;
      t.hold = hold;
      pending_requests.push_back(t);
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val,
                  act_val);
         error_count++;
      end
   endtask

   // Driver: present queued requests, predict each one as it is accepted, and
   // insert a random gap after every request, or none during a sender burst.
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
         clear_timer_model();
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            predict_timer_response(req_cmd, req_write_data);
            next_valid = 1'b0;
            if ($urandom_range(0, 63) == 0) sender_burst = !sender_burst;
            idle_left = sender_burst ? 0 : $urandom_range(0, MaxIdle);
         end
         if (!next_valid) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_requests.size() > 0) begin
               // hold a marked request until the response queue has drained
               if (!pending_requests[0].hold || expected_timer_state.size() == 0) begin
                  req_cmd <= pending_requests[0].cmd;
                  req_write_data <= pending_requests[0].data;
                  void'(pending_requests.pop_front());
                  next_valid = 1'b1;
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // Monitor: compare every accepted response with the oldest prediction, then
   // drop ready for a random stall, except during a receiver burst.
   always @(posedge clock) begin
      logic    next_ready;
      rsp_type exp_r;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         next_ready = rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_timer_state.size() == 0) begin
               $display("%0t: unexpected response: div %0h tima %0h tma %0h tac %0h irq %0b",
                        $time, rsp_div_value, rsp_tima_value, rsp_tma_value,
                        rsp_tac_value, rsp_timer_irq);
               error_count++;
            end else begin
               exp_r = expected_timer_state.pop_front();
               check_field("div_value", exp_r.div_value, rsp_div_value);
               check_field("tima_value", exp_r.tima_value, rsp_tima_value);
               check_field("tma_value", exp_r.tma_value, rsp_tma_value);
               check_field("tac_value", {5'd0, exp_r.tac_value}, {5'd0, rsp_tac_value});
               check_field("timer_irq", {7'd0, exp_r.timer_irq}, {7'd0, rsp_timer_irq});
            end
            next_ready = 1'b0;
            if ($urandom_range(0, 63) == 0) receiver_burst = !receiver_burst;
            stall_left = receiver_burst ? 0 : $urandom_range(0, MaxIdle);
         end
         if (!next_ready) begin
            if (stall_left > 0) stall_left--;
            else next_ready = 1'b1;
         end
         rsp_ready <= next_ready;
      end
   end

   // Watchdog: end the run if the traffic never drains.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [1:0] rate;
      int         period;
      int         steps;
      int         ticks;
      int         next_hold_at;
      bit         hold;

      // Directed: reset state, field extremes, unused codes, masked TAC data,
      // and a TIMA wrap caused by a DIV write, which must not arm a reload.
      queue_request(CmdTick, 8'h00, 1'b0);
      queue_request(CmdWriteTma, 8'hFF, 1'b0);
      queue_request(CmdWriteTma, 8'h00, 1'b0);
      queue_request(CmdWriteTima, 8'h00, 1'b0);
      queue_request(3'd5, 8'hFF, 1'b0);
      queue_request(3'd6, 8'h00, 1'b0);
      queue_request(3'd7, 8'hFF, 1'b0);
      queue_request(CmdWriteTac, {5'd0, 1'b1, RateBit3}, 1'b0);
      queue_request(CmdWriteTima, 8'hFF, 1'b0);
      repeat (7) queue_request(CmdTick, 8'hFF, 1'b0);
      queue_request(CmdWriteDiv, 8'hFF, 1'b0);
      queue_request(CmdWriteTac, 8'hFF, 1'b0);
      queue_request(CmdWriteTac, 8'hF8, 1'b0);
      queue_request(CmdWriteTima, 8'hAA, 1'b0);
      queue_request(CmdWriteTma, 8'h55, 1'b0);
      queue_request(CmdTick, 8'h00, 1'b0);

      // Random: mostly runs that take TIMA through a wrap and the delayed reload,
      // with stray writes sprinkled into the ticks; the rest is plain noise.
      next_hold_at = pending_requests.size();
      while (pending_requests.size() < RequestTarget) begin
         hold = 1'b0;
         if (pending_requests.size() >= next_hold_at) begin
            hold = 1'b1;
            next_hold_at += HoldSpacing;
         end
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: rate = RateBit3;
               6, 7, 8:          rate = RateBit5;
               default:          rate = RateBit7;
            endcase
            period = (rate == RateBit3) ? 16 : (rate == RateBit5) ? 64 : 256;
            steps = (rate == RateBit3) ? $urandom_range(0, 3) :
                    (rate == RateBit5) ? $urandom_range(0, 1) : 0;
            queue_request(CmdWriteTma, 8'($urandom_range(0, 255)), hold);
            queue_request(CmdWriteTac, {5'($urandom_range(0, 31)), 1'b1, rate}, 1'b0);
            queue_request(CmdWriteTima, 8'hFF - 8'(steps), 1'b0);
            ticks = (steps + 1) * period + ReloadDelay + $urandom_range(0, 12);
            repeat (ticks) begin
               if ($urandom_range(0, 15) == 0)
                  queue_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0);
               else
                  queue_request(CmdTick, 8'($urandom_range(0, 255)), 1'b0);
            end
         end else begin
            queue_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), hold);
            repeat ($urandom_range(3, 11))
               queue_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last request to go out and its response to come back.
      while (pending_requests.size() != 0 || req_valid || expected_timer_state.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/dtimer_pkg.sv
rtl/dtimer_core.sv
rtl/divider_timer_with_delayed_reload.sv
sim/tb_divider_timer_with_delayed_reload.sv
